// File: rtl/core/tpfl_pkg.sv
// Shared types and constants of the tabulated pair force lookup.
`default_nettype none
package tpfl_pkg;

  localparam int DATA_W  = 32;
  localparam int IDX_W   = 10;
  localparam int ROOT_W  = 32;
  localparam int RAD_W   = 64;
  localparam int CNT_W   = 11;

  typedef enum logic [1:0] {
    OP_LOAD_ENERGY = 2'd0,
    OP_LOAD_FORCE  = 2'd1,
    OP_QUERY       = 2'd2,
    OP_NONE        = 2'd3
  } op_t;

  typedef enum logic {
    REG_BIN_COUNT   = 1'b0,
    REG_INDEX_SCALE = 1'b1
  } cfg_reg_t;

  // One word as it travels down the pipeline.
  typedef struct packed {
    logic                     vld;
    op_t                      op;
    logic [IDX_W-1:0]         idx;
    logic [DATA_W-1:0]        val;
    logic signed [DATA_W-1:0] dx;
    logic signed [DATA_W-1:0] dy;
    logic signed [DATA_W-1:0] dz;
  } item_t;

endpackage
`default_nettype wire

// File: rtl/core/tpfl_isqrt.sv
// Pipelined integer square root, one result bit per stage, with word carry.
`default_nettype none
module tpfl_isqrt (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire tpfl_pkg::item_t               in_item,
  input  wire logic [tpfl_pkg::RAD_W-1:0]    in_rad,
  output tpfl_pkg::item_t                    out_item,
  output logic [tpfl_pkg::ROOT_W-1:0]        out_root
);

  localparam int NS = tpfl_pkg::ROOT_W;

  tpfl_pkg::item_t                   item_r [NS];
  logic [tpfl_pkg::RAD_W-1:0]        rem_r  [NS];
  logic [tpfl_pkg::ROOT_W-1:0]       root_r [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int I = NS - 1 - k;
    tpfl_pkg::item_t                 item_in;
    logic [tpfl_pkg::RAD_W-1:0]      rem_in;
    logic [tpfl_pkg::RAD_W-1:0]      trial;
    logic [tpfl_pkg::ROOT_W-1:0]     root_in;

    if (k == 0) begin : g_first
      assign item_in = in_item;
      assign rem_in  = in_rad;
      assign root_in = '0;
    end else begin : g_next
      assign item_in = item_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    // (2*root + bit) * bit, with bit = 2^I
    assign trial = ({{(tpfl_pkg::RAD_W-tpfl_pkg::ROOT_W){1'b0}}, root_in} << (I + 1))
                 + ({{(tpfl_pkg::RAD_W-1){1'b0}}, 1'b1} << (2 * I));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        item_r[k].vld <= 1'b0;
      end else begin
        item_r[k].vld <= item_in.vld;
      end
      item_r[k].op  <= item_in.op;
      item_r[k].idx <= item_in.idx;
      item_r[k].val <= item_in.val;
      item_r[k].dx  <= item_in.dx;
      item_r[k].dy  <= item_in.dy;
      item_r[k].dz  <= item_in.dz;
      if (rem_in >= trial) begin
        rem_r[k]  <= rem_in - trial;
        root_r[k] <= root_in | ({{(tpfl_pkg::ROOT_W-1){1'b0}}, 1'b1} << I);
      end else begin
        rem_r[k]  <= rem_in;
        root_r[k] <= root_in;
      end
    end
  end

  assign out_item = item_r[NS-1];
  assign out_root = root_r[NS-1];

endmodule
`default_nettype wire

// File: rtl/core/tabulated_pair_force_lookup.sv
// Top level: tabulated pair potential energy and force lookup pipeline.
//
// Usage:
//   Command words enter on start with in_opcode: load energy entry, load
//   force entry, or query with displacement in_dx/in_dy/in_dz (Q16.16).
//   busy is always low: a new word may enter every cycle.
//   Loads give no result. Each query gives one result word on the out_
//   ports, marked by a one-cycle out_valid strobe; the receiver cannot
//   stall, so results are never held.
//   Pipeline registers from the accepting edge to the result: squares, sum,
//   32 square-root stages, bin multiply, clamp, table read, force multiply,
//   shift and saturate into the output register.
//   Throughput: one word per cycle, set by the fully pipelined root and
//   the single-port table access in the memory stage.
//   Loads travel the same pipe and write the tables in the stage where
//   queries read them, so all table accesses happen in word order.
//   The user must write config (cfg_we/cfg_index/cfg_wdata) only with the
//   pipe empty; the block does not check. Reset clears the pipe valids, sets
//   bin_count to 1024, index_scale to 0; tables are undefined until loaded.
`default_nettype none
module tabulated_pair_force_lookup #(
  parameter int TABLE_DEPTH = 1024,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [1:0]                          in_opcode,
  input  wire logic [tpfl_pkg::IDX_W-1:0]          in_entry_index,
  input  wire logic signed [tpfl_pkg::DATA_W-1:0]  in_entry_value,
  input  wire logic signed [tpfl_pkg::DATA_W-1:0]  in_dx,
  input  wire logic signed [tpfl_pkg::DATA_W-1:0]  in_dy,
  input  wire logic signed [tpfl_pkg::DATA_W-1:0]  in_dz,
  output logic                                     out_valid,
  output logic signed [tpfl_pkg::DATA_W-1:0]       out_energy,
  output logic signed [tpfl_pkg::DATA_W-1:0]       out_force_x,
  output logic signed [tpfl_pkg::DATA_W-1:0]       out_force_y,
  output logic signed [tpfl_pkg::DATA_W-1:0]       out_force_z,
  output logic [tpfl_pkg::IDX_W-1:0]               out_bin_index,
  output logic                                     out_out_of_range,
  input  wire logic                                cfg_we,
  input  wire logic                                cfg_index,
  input  wire logic [tpfl_pkg::DATA_W-1:0]         cfg_wdata
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int DW = tpfl_pkg::DATA_W;

  // Pipe never stalls.
  assign busy = 1'b0;

  // ---------------- configuration ----------------
  logic [tpfl_pkg::CNT_W-1:0] bin_count_r;
  logic [DW-1:0]              index_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r   <= tpfl_pkg::CNT_W'(1024);
      index_scale_r <= '0;
    end else if (cfg_we) begin
      case (tpfl_pkg::cfg_reg_t'(cfg_index))
        tpfl_pkg::REG_BIN_COUNT:   bin_count_r   <= cfg_wdata[tpfl_pkg::CNT_W-1:0];
        tpfl_pkg::REG_INDEX_SCALE: index_scale_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- stage 1: squares ----------------
  tpfl_pkg::item_t   s1_item_r;
  logic [63:0]       sqx_r, sqy_r, sqz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_item_r.vld <= 1'b0;
    end else begin
      s1_item_r.vld <= start && !busy;
    end
    s1_item_r.op  <= tpfl_pkg::op_t'(in_opcode);
    s1_item_r.idx <= in_entry_index;
    s1_item_r.val <= in_entry_value;
    s1_item_r.dx  <= in_dx;
    s1_item_r.dy  <= in_dy;
    s1_item_r.dz  <= in_dz;
    sqx_r <= 64'(in_dx * in_dx);
    sqy_r <= 64'(in_dy * in_dy);
    sqz_r <= 64'(in_dz * in_dz);
  end

  // ---------------- stage 2: sum of squares (fits 64 bits) ----------------
  tpfl_pkg::item_t   s2_item_r;
  logic [63:0]       rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_item_r.vld <= 1'b0;
    end else begin
      s2_item_r.vld <= s1_item_r.vld;
    end
    s2_item_r.op  <= s1_item_r.op;
    s2_item_r.idx <= s1_item_r.idx;
    s2_item_r.val <= s1_item_r.val;
    s2_item_r.dx  <= s1_item_r.dx;
    s2_item_r.dy  <= s1_item_r.dy;
    s2_item_r.dz  <= s1_item_r.dz;
    rad_r <= sqx_r + sqy_r + sqz_r;
  end

  // ---------------- square root ----------------
  tpfl_pkg::item_t                  s3_item;
  logic [tpfl_pkg::ROOT_W-1:0]      s3_root;

  tpfl_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (s2_item_r),
    .in_rad   (rad_r),
    .out_item (s3_item),
    .out_root (s3_root)
  );

  // ---------------- stage 4: distance times index scale ----------------
  tpfl_pkg::item_t   s4_item_r;
  logic [63:0]       bprod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_item_r.vld <= 1'b0;
    end else begin
      s4_item_r.vld <= s3_item.vld;
    end
    s4_item_r.op  <= s3_item.op;
    s4_item_r.idx <= s3_item.idx;
    s4_item_r.val <= s3_item.val;
    s4_item_r.dx  <= s3_item.dx;
    s4_item_r.dy  <= s3_item.dy;
    s4_item_r.dz  <= s3_item.dz;
    bprod_r <= {32'd0, s3_root} * {32'd0, index_scale_r};
  end

  // ---------------- stage 5: bin clamp and table address ----------------
  logic [63:0]    bin_raw;
  logic [31:0]    cnt;
  logic [31:0]    bin_nxt;
  logic           oor_nxt;
  logic [31:0]    idx_ext;
  logic [AW-1:0]  addr_nxt;
  logic           we_e_nxt, we_f_nxt;

  always_comb begin
    bin_raw = bprod_r >> (2 * FRAC_BITS);
    if (bin_count_r == '0) begin
      cnt = 32'd1;
    end else if (32'(bin_count_r) > 32'(TABLE_DEPTH)) begin
      cnt = 32'(TABLE_DEPTH);
    end else begin
      cnt = 32'(bin_count_r);
    end
    if (bin_raw >= {32'd0, cnt}) begin
      bin_nxt = cnt - 32'd1;
      oor_nxt = 1'b1;
    end else begin
      bin_nxt = bin_raw[31:0];
      oor_nxt = 1'b0;
    end
    idx_ext  = 32'(s4_item_r.idx);
    we_e_nxt = s4_item_r.vld && (s4_item_r.op == tpfl_pkg::OP_LOAD_ENERGY)
               && (idx_ext < 32'(TABLE_DEPTH));
    we_f_nxt = s4_item_r.vld && (s4_item_r.op == tpfl_pkg::OP_LOAD_FORCE)
               && (idx_ext < 32'(TABLE_DEPTH));
    if (s4_item_r.op == tpfl_pkg::OP_QUERY) begin
      addr_nxt = bin_nxt[AW-1:0];
    end else begin
      addr_nxt = idx_ext[AW-1:0];
    end
  end

  logic                           s5_q_r;
  logic                           we_e_r, we_f_r;
  logic [AW-1:0]                  addr_r;
  logic [DW-1:0]                  wdata_r;
  logic signed [DW-1:0]           s5_dx_r, s5_dy_r, s5_dz_r;
  logic [tpfl_pkg::IDX_W-1:0]     s5_bin_r;
  logic                           s5_oor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_q_r <= 1'b0;
      we_e_r <= 1'b0;
      we_f_r <= 1'b0;
    end else begin
      s5_q_r <= s4_item_r.vld && (s4_item_r.op == tpfl_pkg::OP_QUERY);
      we_e_r <= we_e_nxt;
      we_f_r <= we_f_nxt;
    end
    addr_r   <= addr_nxt;
    wdata_r  <= s4_item_r.val;
    s5_dx_r  <= s4_item_r.dx;
    s5_dy_r  <= s4_item_r.dy;
    s5_dz_r  <= s4_item_r.dz;
    s5_bin_r <= bin_nxt[tpfl_pkg::IDX_W-1:0];
    s5_oor_r <= oor_nxt;
  end

  // ---------------- stage 6: table memories ----------------
  logic [DW-1:0] energy_mem [TABLE_DEPTH];
  logic [DW-1:0] force_mem  [TABLE_DEPTH];
  logic [DW-1:0] e_rd_r, f_rd_r;

  always_ff @(posedge clk) begin
    if (we_e_r) begin
      energy_mem[addr_r] <= wdata_r;
    end
    e_rd_r <= energy_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (we_f_r) begin
      force_mem[addr_r] <= wdata_r;
    end
    f_rd_r <= force_mem[addr_r];
  end

  logic                           s6_q_r;
  logic signed [DW-1:0]           s6_dx_r, s6_dy_r, s6_dz_r;
  logic [tpfl_pkg::IDX_W-1:0]     s6_bin_r;
  logic                           s6_oor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_q_r <= 1'b0;
    end else begin
      s6_q_r <= s5_q_r;
    end
    s6_dx_r  <= s5_dx_r;
    s6_dy_r  <= s5_dy_r;
    s6_dz_r  <= s5_dz_r;
    s6_bin_r <= s5_bin_r;
    s6_oor_r <= s5_oor_r;
  end

  // ---------------- stage 7: force products ----------------
  logic                           s7_q_r;
  logic signed [63:0]             px_r, py_r, pz_r;
  logic [DW-1:0]                  s7_energy_r;
  logic [tpfl_pkg::IDX_W-1:0]     s7_bin_r;
  logic                           s7_oor_r;
  logic signed [DW-1:0]           fval;

  assign fval = f_rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_q_r <= 1'b0;
    end else begin
      s7_q_r <= s6_q_r;
    end
    px_r        <= 64'(s6_dx_r * fval);
    py_r        <= 64'(s6_dy_r * fval);
    pz_r        <= 64'(s6_dz_r * fval);
    s7_energy_r <= e_rd_r;
    s7_bin_r    <= s6_bin_r;
    s7_oor_r    <= s6_oor_r;
  end

  // ---------------- stage 8: floor shift, saturate, output ----------------
  function automatic logic [DW-1:0] shift_sat(input logic signed [63:0] p);
    logic signed [63:0] q;
    q = p >>> FRAC_BITS;
    if (q > 64'sd2147483647) begin
      shift_sat = 32'h7FFF_FFFF;
    end else if (q < -64'sd2147483648) begin
      shift_sat = 32'h8000_0000;
    end else begin
      shift_sat = q[DW-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s7_q_r;
    end
    out_energy       <= s7_energy_r;
    out_force_x      <= shift_sat(px_r);
    out_force_y      <= shift_sat(py_r);
    out_force_z      <= shift_sat(pz_r);
    out_bin_index    <= s7_bin_r;
    out_out_of_range <= s7_oor_r;
  end

endmodule
`default_nettype wire

// File: tb/sv/tb_tabulated_pair_force_lookup.sv
// Testbench for the tabulated pair force lookup: directed table, then random words.
`timescale 1ns / 1ps
module tb_tabulated_pair_force_lookup;

  localparam int DEPTH       = 1024;
  localparam int FILLED      = 256;
  localparam int FRAC        = 16;
  localparam int LATENCY     = 39;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_opcode = tpfl_pkg::OP_NONE;
  logic [tpfl_pkg::IDX_W-1:0] in_entry_index = '0;
  logic signed [tpfl_pkg::DATA_W-1:0] in_entry_value = '0;
  logic signed [tpfl_pkg::DATA_W-1:0] in_dx = '0;
  logic signed [tpfl_pkg::DATA_W-1:0] in_dy = '0;
  logic signed [tpfl_pkg::DATA_W-1:0] in_dz = '0;
  logic out_valid;
  logic signed [tpfl_pkg::DATA_W-1:0] out_energy, out_force_x, out_force_y, out_force_z;
  logic [tpfl_pkg::IDX_W-1:0] out_bin_index;
  logic out_out_of_range;
  logic cfg_we = 1'b0;
  logic cfg_index = tpfl_pkg::REG_BIN_COUNT;
  logic [tpfl_pkg::DATA_W-1:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  tabulated_pair_force_lookup DUT (
    .clk, .rst_n, .start, .busy, .in_opcode, .in_entry_index, .in_entry_value,
    .in_dx, .in_dy, .in_dz, .out_valid, .out_energy, .out_force_x, .out_force_y,
    .out_force_z, .out_bin_index, .out_out_of_range, .cfg_we, .cfg_index, .cfg_wdata
  );

  // One expected result word.
  typedef struct packed {
    logic signed [tpfl_pkg::DATA_W-1:0] energy;
    logic signed [tpfl_pkg::DATA_W-1:0] fx;
    logic signed [tpfl_pkg::DATA_W-1:0] fy;
    logic signed [tpfl_pkg::DATA_W-1:0] fz;
    logic [tpfl_pkg::IDX_W-1:0]         bin;
    logic                               oor;
  } lookup_t;

  // Predictor state: our own copy of tables and registers.
  logic [tpfl_pkg::DATA_W-1:0] energy_mem [DEPTH];
  logic [tpfl_pkg::DATA_W-1:0] force_mem [DEPTH];
  bit   energy_set [DEPTH];
  bit   force_set [DEPTH];
  logic [tpfl_pkg::CNT_W-1:0]  bins_in_use;
  logic [tpfl_pkg::DATA_W-1:0] scale_q16;

  lookup_t pending_lookups[$];
  int errors = 0;
  int cycle = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("ERROR @%0d: %s got %h want %h", cycle, what, got, want);
  endtask

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // d*f >>> FRAC (floor), saturated to 32 bits.
  function automatic logic signed [31:0] scale_force(input logic signed [31:0] d,
                                                     input logic signed [31:0] f);
    logic signed [63:0] p, q;
    p = 64'(d) * 64'(f);
    q = p >>> FRAC;
    if (q > 64'sh7FFFFFFF) q = 64'sh7FFFFFFF;
    if (q < -64'sh80000000) q = -64'sh80000000;
    return q[31:0];
  endfunction

  function automatic lookup_t predict_lookup(input logic signed [31:0] dx,
                                             input logic signed [31:0] dy,
                                             input logic signed [31:0] dz);
    lookup_t r;
    logic [63:0] sq, dist_q16, bin;
    logic [95:0] prod;
    int cnt;
    sq = 64'(64'(dx) * 64'(dx)) + 64'(64'(dy) * 64'(dy)) + 64'(64'(dz) * 64'(dz));
    dist_q16 = isqrt(sq);
    prod = 96'(dist_q16) * 96'(scale_q16);
    bin = 64'(prod >> (2 * FRAC));
    cnt = int'(bins_in_use);
    if (cnt == 0) cnt = 1;
    if (cnt > DEPTH) cnt = DEPTH;
    r.oor = 1'b0;
    if (bin >= 64'(cnt)) begin
      bin = 64'(cnt - 1);
      r.oor = 1'b1;
    end
    r.bin = bin[tpfl_pkg::IDX_W-1:0];
    r.energy = energy_mem[r.bin];
    r.fx = scale_force(dx, force_mem[r.bin]);
    r.fy = scale_force(dy, force_mem[r.bin]);
    r.fz = scale_force(dz, force_mem[r.bin]);
    return r;
  endfunction

  // True when the bin a query lands in has both entries loaded.
  function automatic bit query_safe(input logic signed [31:0] dx, input logic signed [31:0] dy,
                                    input logic signed [31:0] dz);
    lookup_t r;
    r = predict_lookup(dx, dy, dz);
    return energy_set[r.bin] && force_set[r.bin];
  endfunction

  // Result checker at the rising edge.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (rst_n && out_valid) begin
      if (pending_lookups.size() == 0) begin
        report("unexpected word", 64'(out_bin_index), '0);
      end else begin
        lookup_t e;
        e = pending_lookups.pop_front();
        if (out_energy !== e.energy) report("energy", 64'(out_energy), 64'(e.energy));
        if (out_force_x !== e.fx) report("force_x", 64'(out_force_x), 64'(e.fx));
        if (out_force_y !== e.fy) report("force_y", 64'(out_force_y), 64'(e.fy));
        if (out_force_z !== e.fz) report("force_z", 64'(out_force_z), 64'(e.fz));
        if (out_bin_index !== e.bin) report("bin_index", 64'(out_bin_index), 64'(e.bin));
        if (out_out_of_range !== e.oor)
          report("out_of_range", 64'(out_out_of_range), 64'(e.oor));
      end
    end
    if (cycle >= CYCLE_LIMIT) begin
      $display("timeout");
      $display("tabulated_pair_force_lookup: mismatch");
      $finish;
    end
  end

  bit no_idle = 1'b0;

  // Present one word at the falling edge until accepted; idles at random.
  // start is left high on return; the next call or drain() drives it.
  task automatic send_word(input tpfl_pkg::op_t op, input logic [tpfl_pkg::IDX_W-1:0] idx,
                           input logic [31:0] val, input logic signed [31:0] dx,
                           input logic signed [31:0] dy, input logic signed [31:0] dz);
    while (!no_idle && $urandom_range(99) < 18) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_opcode <= op;
    in_entry_index <= idx;
    in_entry_value <= val;
    in_dx <= dx;
    in_dy <= dy;
    in_dz <= dz;
    @(posedge clk);
    while (busy) @(posedge clk);
    // accepted at this edge: update predictor
    case (op)
      tpfl_pkg::OP_LOAD_ENERGY: begin
        energy_mem[idx] = val;
        energy_set[idx] = 1'b1;
      end
      tpfl_pkg::OP_LOAD_FORCE: begin
        force_mem[idx] = val;
        force_set[idx] = 1'b1;
      end
      tpfl_pkg::OP_QUERY: pending_lookups.push_back(predict_lookup(dx, dy, dz));
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Stop sending, wait for the pipe to drain, then some latency margin.
  task automatic drain();
    int n;
    n = 0;
    start <= 1'b0;
    while (pending_lookups.size() != 0 && n < 10 * LATENCY) begin
      @(negedge clk);
      n++;
    end
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_reg(input tpfl_pkg::cfg_reg_t r, input logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (r == tpfl_pkg::REG_BIN_COUNT) bins_in_use = v[tpfl_pkg::CNT_W-1:0];
    else scale_q16 = v;
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(4))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
      default: return $urandom;
    endcase
  endfunction

  // Random displacement: mostly within a few units so bins spread.
  function automatic logic [31:0] rand_disp();
    case ($urandom_range(9))
      0: return $urandom;
      1: return ($urandom_range(1)) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'($urandom_range(0, 32'h000FFFFF)) - 32'h00080000;
    endcase
  endfunction

  // Directed stimulus: op, index, value, dx, dy, dz.
  typedef struct {
    tpfl_pkg::op_t op;
    logic [tpfl_pkg::IDX_W-1:0] idx;
    logic [31:0] val;
    logic [31:0] dx, dy, dz;
  } row_t;

  row_t directed[] = '{
    '{tpfl_pkg::OP_LOAD_ENERGY, 10'd0,    32'h0001_0000, '0, '0, '0},
    '{tpfl_pkg::OP_LOAD_FORCE,  10'd0,    32'h0002_0000, '0, '0, '0},
    '{tpfl_pkg::OP_LOAD_ENERGY, 10'd1023, 32'h7FFF_FFFF, '0, '0, '0},
    '{tpfl_pkg::OP_LOAD_FORCE,  10'd1023, 32'h8000_0000, '0, '0, '0},
    '{tpfl_pkg::OP_NONE,        10'd5,    32'hDEAD_BEEF, '0, '0, '0},
    '{tpfl_pkg::OP_QUERY, '0, '0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
    '{tpfl_pkg::OP_QUERY, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF},
    '{tpfl_pkg::OP_QUERY, '0, '0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
    '{tpfl_pkg::OP_QUERY, '0, '0, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000}
  };

  // Hand-read expectation for the zero query after reset (scale 0 -> bin 0).
  lookup_t hand_zero = '{32'h0001_0000, 32'd0, 32'd0, 32'd0, 10'd0, 1'b0};

  initial begin
    lookup_t e;
    logic [31:0] dx, dy, dz;
    bins_in_use = 11'd1024;
    scale_q16 = '0;
    foreach (energy_set[i]) begin
      energy_set[i] = 0;
      force_set[i] = 0;
    end
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Phase 1: reset settings, directed table.
    foreach (directed[i]) begin
      send_word(directed[i].op, directed[i].idx, directed[i].val,
                directed[i].dx, directed[i].dy, directed[i].dz);
      if (i == 5) begin
        // zero displacement after reset: bin 0, energy 1.0, zero force
        e = pending_lookups[$];
        if (e !== hand_zero) report("directed zero query", 64'(e.energy), 64'(hand_zero.energy));
      end
    end
    drain();

    // Fill the low bins; the last bin was loaded above.
    for (int i = 0; i < FILLED; i++) begin
      send_word(tpfl_pkg::OP_LOAD_ENERGY, i[tpfl_pkg::IDX_W-1:0], rand_val(), '0, '0, '0);
      send_word(tpfl_pkg::OP_LOAD_FORCE, i[tpfl_pkg::IDX_W-1:0], rand_val(), '0, '0, '0);
    end
    drain();

    // Extremes of registers: zero and huge bin counts, big scale.
    write_reg(tpfl_pkg::REG_BIN_COUNT, 32'd0);
    write_reg(tpfl_pkg::REG_INDEX_SCALE, 32'hFFFF_FFFF);
    send_word(tpfl_pkg::OP_QUERY, '0, '0, 32'h0001_0000, '0, '0);
    send_word(tpfl_pkg::OP_QUERY, '0, '0, '0, '0, '0);
    drain();
    write_reg(tpfl_pkg::REG_BIN_COUNT, 32'd2047);
    send_word(tpfl_pkg::OP_QUERY, '0, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    drain();

    // Random phases with several settings.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(tpfl_pkg::REG_BIN_COUNT, 32'd256);
          write_reg(tpfl_pkg::REG_INDEX_SCALE, 32'h0010_0000);
        end
        1: begin
          write_reg(tpfl_pkg::REG_BIN_COUNT, 32'd1);
          write_reg(tpfl_pkg::REG_INDEX_SCALE, 32'h0001_0000);
        end
        2: begin
          write_reg(tpfl_pkg::REG_BIN_COUNT, 32'd256);
          write_reg(tpfl_pkg::REG_INDEX_SCALE, $urandom);
        end
        3: begin
          write_reg(tpfl_pkg::REG_BIN_COUNT, 32'd1500);
          write_reg(tpfl_pkg::REG_INDEX_SCALE, 32'h0000_8000);
        end
        default: begin
          write_reg(tpfl_pkg::REG_BIN_COUNT, 32'($urandom_range(1, 256)));
          write_reg(tpfl_pkg::REG_INDEX_SCALE, 32'($urandom_range(0, 32'h0100_0000)));
        end
      endcase
      no_idle = (ph == 3);
      for (int k = 0; k < 195; k++) begin
        if ($urandom_range(99) < 15) begin
          send_word(tpfl_pkg::op_t'($urandom_range(1)), tpfl_pkg::IDX_W'($urandom),
                    rand_val(), $urandom, $urandom, $urandom);
        end else if ($urandom_range(99) < 2) begin
          send_word(tpfl_pkg::OP_NONE, tpfl_pkg::IDX_W'($urandom), $urandom,
                    $urandom, $urandom, $urandom);
        end else begin
          dx = rand_disp();
          dy = rand_disp();
          dz = rand_disp();
          // queries that would land on an unloaded bin fall back to bin 0
          if (!query_safe(dx, dy, dz)) begin
            dx = '0;
            dy = '0;
            dz = '0;
          end
          send_word(tpfl_pkg::OP_QUERY, tpfl_pkg::IDX_W'($urandom), $urandom, dx, dy, dz);
        end
      end
      no_idle = 1'b0;
      drain();
    end

    drain();
    if (errors == 0 && pending_lookups.size() == 0) begin
      $display("tabulated_pair_force_lookup: match");
    end else begin
      if (pending_lookups.size() != 0) $display("ERROR: %0d words never arrived",
                                                 pending_lookups.size());
      $display("tabulated_pair_force_lookup: mismatch");
    end
    $finish;
  end
endmodule
